[design/sdrs_pkg.sv]
// ----------------------------------------------------------------------------
// sdrs_pkg
// Shared widths and controller/datapath command and status types for the
// SCAN disk request scheduler.
// ----------------------------------------------------------------------------
package sdrs_pkg;

  localparam int TRACK_W = 8;
  localparam int TOTAL_W = 9;
  localparam int OUT_DATA_W = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;       // write the incoming request into the store
    logic open_batch;  // start serving: reset sweep and total, load the pending count
    logic scan_clear;  // restart the nearest-request scan
    logic scan_issue;  // read the next slot of the scan
    logic serve;       // emit the best candidate and retire its slot
    logic flip;        // reverse the sweep direction
  } sdrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;   // the next stored request fills the store
    logic rd_last;     // the scan is reading its final slot
    logic found;       // the finished scan found a candidate
    logic rem_one;     // one request is left in the batch
    logic out_busy;    // the output register holds an untaken result
  } sdrs_sts_t;

endpackage

[design/sdrs_ram.sv]
// ----------------------------------------------------------------------------
// sdrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sdrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/sdrs_ctrl.sv]
// ----------------------------------------------------------------------------
// sdrs_ctrl
// Controller: loads requests, then runs one slot scan per service until the
// batch is empty, reversing the sweep when a scan finds nothing.
// ----------------------------------------------------------------------------
module sdrs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tlast,
  output logic               in_tready,
  input  sdrs_pkg::sdrs_sts_t sts,
  output sdrs_pkg::sdrs_cmd_t cmd
);

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == S_LOAD);
    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          cmd.store = 1'b1;
          if (in_tlast || sts.fill_last) begin
            cmd.open_batch = 1'b1;
            cmd.scan_clear = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The compare of the final slot completes in this cycle.
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.found) begin
          if (!sts.out_busy) begin
            cmd.serve = 1'b1;
            if (sts.rem_one) begin
              state_nxt = S_LOAD;
            end else begin
              cmd.scan_clear = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
        end else begin
          cmd.flip       = 1'b1;
          cmd.scan_clear = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/sdrs_dp.sv]
// ----------------------------------------------------------------------------
// sdrs_dp
// Datapath: request store, pending flags, head and sweep state, the
// slot-by-slot nearest-request compare and the output register.
// ----------------------------------------------------------------------------
module sdrs_dp #(
  parameter int DEPTH      = 16,
  parameter int NUM_TRACKS = 200
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sdrs_pkg::sdrs_cmd_t               cmd,
  output sdrs_pkg::sdrs_sts_t               sts,
  input  logic [sdrs_pkg::TRACK_W-1:0]      req_track,
  input  logic                              cfg_wr,
  input  logic [sdrs_pkg::TRACK_W-1:0]      cfg_track,
  output logic [sdrs_pkg::TRACK_W-1:0]      start_track,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sdrs_pkg::TRACK_W-1:0]      out_track,
  output logic [sdrs_pkg::TRACK_W-1:0]      out_dist,
  output logic [sdrs_pkg::TOTAL_W-1:0]      out_total,
  output logic                              out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = sdrs_pkg::TRACK_W;
  localparam int SW = sdrs_pkg::TOTAL_W;
  localparam int unsigned TOP = NUM_TRACKS - 1;

  function automatic logic [TW-1:0] clamp_track(input logic [TW-1:0] v);
    logic [TW-1:0] res;
    res = v;
    if (32'(v) > TOP) begin
      res = TOP[TW-1:0];
    end
    return res;
  endfunction

  logic [CW-1:0]    fill_r;
  logic [CW-1:0]    remain_r;
  logic [DEPTH-1:0] pending_r;
  logic [TW-1:0]    head_r;
  logic [TW-1:0]    start_r;
  logic             up_r;
  logic [SW-1:0]    total_r;

  logic [AW-1:0]    rd_idx_r;
  logic [AW-1:0]    cmp_idx_r;
  logic             cmp_en_r;
  logic             found_r;
  logic [AW-1:0]    best_slot_r;
  logic [TW-1:0]    best_track_r;
  logic [TW-1:0]    best_dist_r;

  logic             out_valid_r;
  logic [TW-1:0]    out_track_r;
  logic [TW-1:0]    out_dist_r;
  logic [SW-1:0]    out_total_r;
  logic             out_last_r;

  logic [TW-1:0]    rd_track;
  logic             cand;
  logic [TW-1:0]    cand_dist;
  logic [SW:0]      sum;
  logic [SW-1:0]    total_nxt;

  sdrs_ram #(
    .WIDTH (TW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (fill_r[AW-1:0]),
    .wdata (clamp_track(req_track)),
    .re    (cmd.scan_issue),
    .raddr (rd_idx_r),
    .rdata (rd_track)
  );

  // A slot is a candidate when pending and on the sweep side of the head.
  always_comb begin
    if (up_r) begin
      cand      = pending_r[cmp_idx_r] && (rd_track >= head_r);
      cand_dist = rd_track - head_r;
    end else begin
      cand      = pending_r[cmp_idx_r] && (rd_track <= head_r);
      cand_dist = head_r - rd_track;
    end
    sum       = {1'b0, total_r} + {{(SW + 1 - TW){1'b0}}, best_dist_r};
    total_nxt = sum[SW] ? {SW{1'b1}} : sum[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      remain_r    <= '0;
      pending_r   <= '0;
      head_r      <= '0;
      start_r     <= '0;
      up_r        <= 1'b1;
      total_r     <= '0;
      rd_idx_r    <= '0;
      cmp_en_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        start_r <= clamp_track(cfg_track);
        head_r  <= clamp_track(cfg_track);
      end
      if (cmd.store) begin
        pending_r[fill_r[AW-1:0]] <= 1'b1;
      end
      if (cmd.open_batch) begin
        fill_r   <= '0;
        remain_r <= fill_r + 1'b1;
        up_r     <= 1'b1;
        total_r  <= '0;
      end else if (cmd.store) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.flip) begin
        up_r <= !up_r;
      end
      cmp_en_r <= cmd.scan_issue;
      if (cmd.scan_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (cmp_en_r && cand && (!found_r || cand_dist < best_dist_r)) begin
        found_r <= 1'b1;
      end
      if (cmd.scan_clear) begin
        rd_idx_r <= '0;
        found_r  <= 1'b0;
      end
      if (cmd.serve) begin
        head_r                 <= best_track_r;
        total_r                <= total_nxt;
        pending_r[best_slot_r] <= 1'b0;
        remain_r               <= remain_r - 1'b1;
        out_valid_r            <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      cmp_idx_r <= rd_idx_r;
    end
    if (cmp_en_r && cand && (!found_r || cand_dist < best_dist_r)) begin
      best_slot_r  <= cmp_idx_r;
      best_track_r <= rd_track;
      best_dist_r  <= cand_dist;
    end
    if (cmd.serve) begin
      out_track_r <= best_track_r;
      out_dist_r  <= best_dist_r;
      out_total_r <= total_nxt;
      out_last_r  <= (remain_r == CW'(1));
    end
  end

  assign sts.fill_last = (fill_r == CW'(DEPTH - 1));
  assign sts.rd_last   = (rd_idx_r == AW'(DEPTH - 1));
  assign sts.found     = found_r;
  assign sts.rem_one   = (remain_r == CW'(1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign start_track = start_r;
  assign out_valid   = out_valid_r;
  assign out_track   = out_track_r;
  assign out_dist    = out_dist_r;
  assign out_total   = out_total_r;
  assign out_last    = out_last_r;

endmodule

[design/scan_disk_request_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// scan_disk_request_scheduler_unit
// SCAN (elevator) scheduler for batches of disk track requests.
// ----------------------------------------------------------------------------
// Requests are taken one per cycle while the unit is loading, and stored until
// a transfer with tlast, or the DEPTH-th request, closes the batch. The batch
// is then served in elevator order starting upward from the head, which
// carries over between batches and is set by writing start_track. Each service
// runs one scan of the request memory, one slot read per cycle through its
// single read port, and a service whose scan finds nothing first reverses the
// sweep and scans again. The next batch may start loading while the final
// result of the previous one still waits in the output register.
module scan_disk_request_scheduler_unit #(
  parameter int DEPTH      = 16,
  parameter int NUM_TRACKS = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] request_track
  input  logic        in_tlast,    // last_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] served_track, [15:8] seek_distance,
                                   // [24:16] batch_total, [31:25] zero
  output logic        out_tlast,   // last_served
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  sdrs_pkg::sdrs_cmd_t cmd;
  sdrs_pkg::sdrs_sts_t sts;

  logic                            cfg_wr;
  logic [sdrs_pkg::TRACK_W-1:0]    start_track;
  logic [sdrs_pkg::TRACK_W-1:0]    out_track;
  logic [sdrs_pkg::TRACK_W-1:0]    out_dist;
  logic [sdrs_pkg::TOTAL_W-1:0]    out_total;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {24'd0, start_track} : 32'd0;

  sdrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sdrs_dp #(
    .DEPTH      (DEPTH),
    .NUM_TRACKS (NUM_TRACKS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .req_track   (in_tdata),
    .cfg_wr      (cfg_wr),
    .cfg_track   (cfg_pwdata[7:0]),
    .start_track (start_track),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_track   (out_track),
    .out_dist    (out_dist),
    .out_total   (out_total),
    .out_last    (out_tlast)
  );

  assign out_tdata = {7'd0, out_total, out_dist, out_track};

endmodule

[design/sdrs_chk.sv]
// ----------------------------------------------------------------------------
// sdrs_chk
// Port-level checks for the SCAN disk request scheduler.
// ----------------------------------------------------------------------------
module sdrs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The running total always covers the latest seek.
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[24:16] >= {1'b0, out_tdata[15:8]})
    else $error("batch total below seek distance");

  // Readback holds only the 8-bit register, and the port is always ready.
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_prdata[31:8] == 24'd0 && cfg_pready)
    else $error("bad register readback");

endmodule

bind scan_disk_request_scheduler_unit sdrs_chk u_sdrs_chk (.*);
